// ----- rtl/core/lexical_token_classifier_top_assert.svh -----
// assertion helpers shared by the token classifier rtl
`ifndef LEXICAL_TOKEN_CLASSIFIER_TOP_ASSERT_SVH
`define LEXICAL_TOKEN_CLASSIFIER_TOP_ASSERT_SVH

// condition holds at every edge outside reset
`define LTC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lexical_token_classifier: invariant violated");

// consequent holds in the same cycle as the antecedent
`define LTC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lexical_token_classifier: implication violated");

// consequent holds in the cycle after the antecedent
`define LTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lexical_token_classifier: next-cycle check violated");

`endif

// ----- rtl/core/ltc_pkg.sv -----
package ltc_pkg;

  localparam int MAX_TOKEN_CHARS = 8;
  localparam int NUM_KEYWORDS = 7;

  // output queue, depth must be a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] CLS_OPERATOR   = 3'd0;
  localparam logic [2:0] CLS_DELIMITER  = 3'd1;
  localparam logic [2:0] CLS_CONSTANT   = 3'd2;
  localparam logic [2:0] CLS_SPECIAL    = 3'd3;
  localparam logic [2:0] CLS_KEYWORD    = 3'd4;
  localparam logic [2:0] CLS_IDENTIFIER = 3'd5;

  // keywords packed first character in the low byte
  localparam logic [39:0] KW_TEXT [NUM_KEYWORDS] = '{
    40'h000074_6e69,  // int
    40'h0000726f66,   // for
    40'h74616f6c66,   // float
    40'h0072616863,   // char
    40'h656c696877,   // while
    40'h0000006669,   // if
    40'h0065736c65    // else
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd3, 4'd3, 4'd5, 4'd4, 4'd5, 4'd2, 4'd4
  };

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    logic [2:0]  token_class;
    logic [63:0] token_text;
    logic [3:0]  token_length;
    logic        truncated;
    logic        run_end;
  } token_item_t;

  // results of one input transaction handed to the output queue
  typedef struct packed {
    logic [1:0]  n;
    token_item_t first;
    token_item_t second;
  } ltc_push_t;

  function automatic logic is_op(input logic [7:0] c);
    return c == "*" || c == "/" || c == "+" || c == "-" || c == "=";
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == "(" || c == ")" || c == "{" || c == "}" || c == ";" || c == ",";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // text is zero above len, so a full-width compare plus length match suffices
  function automatic logic is_keyword(input logic [63:0] text, input logic [3:0] len);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (len == KW_LEN[k] && text == {24'h0, KW_TEXT[k]}) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [2:0] classify(input logic [63:0] text, input logic [3:0] len,
                                          input logic ovf);
    logic [7:0]  c;
    logic [2:0]  cls;
    c = text[7:0];
    priority if (len == 4'd1 && !is_letter(c)) begin
      priority if (is_op(c)) cls = CLS_OPERATOR;
      else if (is_delim(c)) cls = CLS_DELIMITER;
      else if (c >= "0" && c <= "9") cls = CLS_CONSTANT;
      else cls = CLS_SPECIAL;
    end else if (ovf) begin
      cls = CLS_IDENTIFIER;
    end else if (is_keyword(text, len)) begin
      cls = CLS_KEYWORD;
    end else begin
      cls = CLS_IDENTIFIER;
    end
    return cls;
  endfunction

endpackage

// ----- rtl/core/ltc_out_fifo.sv -----
module ltc_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  ltc_pkg::ltc_push_t   push,
  output logic                 room2,
  output logic                 token_valid,
  input  logic                 token_ready,
  output ltc_pkg::token_item_t token_item
);

  ltc_pkg::token_item_t entries [ltc_pkg::FIFO_DEPTH];
  logic [ltc_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [ltc_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [ltc_pkg::FIFO_PTR_W-1:0] wr_ptr_plus1;
  logic [ltc_pkg::FIFO_CNT_W-1:0] count;
  logic [ltc_pkg::FIFO_CNT_W-1:0] count_next;
  logic                           pop;

  assign token_valid  = count != '0;
  assign token_item   = entries[rd_ptr];
  assign pop          = token_valid && token_ready;
  assign room2        = count <= ltc_pkg::FIFO_CNT_W'(ltc_pkg::FIFO_DEPTH - 2);
  assign wr_ptr_plus1 = wr_ptr + 1'b1;
  assign count_next   = count + ltc_pkg::FIFO_CNT_W'(push.n) - ltc_pkg::FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count  <= count_next;
      wr_ptr <= wr_ptr + ltc_pkg::FIFO_PTR_W'(push.n);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) entries[wr_ptr] <= push.first;
    if (push.n == 2'd2) entries[wr_ptr_plus1] <= push.second;
  end

endmodule

// ----- rtl/core/lexical_token_classifier_top.sv -----
// lexical token classifier
// input channel char_valid/char_ready/char_item carries one source byte per
// transaction plus an end-of-text flag. output channel token_valid/
// token_ready/token_item carries classified tokens in text order.
// an input transaction yields zero, one or two tokens: a pending word
// followed by an operator or delimiter gives two, with run_end set on the
// last token of the transaction.
// a token passes through the input register and then the output queue
// before the receiver can take it.
// throughput: one byte per cycle while the queue has room for two
// tokens; the four-entry queue absorbs a transaction that makes two.
// a held byte is only consumed while the queue has room for two tokens,
// so a stalled receiver backs up into char_ready and nothing is dropped.
// reset (rst, synchronous) empties the input register and the queue and
// clears the pending word; char_ready is low while rst is high.
// words longer than the buffer keep their first characters and come out
// with truncated set.
`include "lexical_token_classifier_top_assert.svh"

module lexical_token_classifier_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_ready,
  input  ltc_pkg::char_item_t  char_item,
  output logic                 token_valid,
  input  logic                 token_ready,
  output ltc_pkg::token_item_t token_item
);

  localparam int MAXC = ltc_pkg::MAX_TOKEN_CHARS;

  logic                item_valid;
  ltc_pkg::char_item_t item;
  logic                item_fire;
  logic                room2;

  logic [7:0] word_buffer [MAXC];
  logic [3:0] word_length;
  logic       word_overflow;
  logic [3:0] word_length_next;
  logic       word_overflow_next;

  logic [7:0]  c;
  logic        is_od;
  logic        is_ws;
  logic        is_plain;
  logic        room_left;
  logic        append;
  logic        pending;
  logic        flush;
  logic [3:0]  len_eff;
  logic        ovf_eff;
  logic [63:0] text_eff;
  logic [7:0]  byte_eff;

  ltc_pkg::token_item_t word_res;
  ltc_pkg::token_item_t tok_res;
  ltc_pkg::ltc_push_t   push;

  assign item_fire  = item_valid && room2;
  assign char_ready = !rst && (!item_valid || item_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (char_ready) begin
      item_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) item <= char_item;
  end

  always_comb begin
    c         = item.char_in;
    is_od     = ltc_pkg::is_op(c) || ltc_pkg::is_delim(c);
    is_ws     = ltc_pkg::is_space(c);
    is_plain  = !is_od && !is_ws;
    room_left = word_length < 4'(MAXC);
    append    = is_plain && room_left;
    pending   = word_length != 4'd0;
    len_eff   = append ? word_length + 4'd1 : word_length;
    ovf_eff   = word_overflow || (is_plain && !room_left);
    // operator, delimiter and whitespace flush what was there; a word byte
    // with end of text flushes the word including itself
    flush     = is_plain ? item.end_of_text : pending;

    // view of the word with this byte appended, masked above its length
    text_eff = '0;
    for (int i = 0; i < MAXC; i++) begin
      byte_eff = (append && word_length == 4'(i)) ? c : word_buffer[i];
      text_eff[8*i +: 8] = (4'(i) < len_eff) ? byte_eff : 8'h00;
    end

    word_res.token_class  = ltc_pkg::classify(text_eff, len_eff, ovf_eff);
    word_res.token_text   = text_eff;
    word_res.token_length = len_eff;
    word_res.truncated    = ovf_eff;
    word_res.run_end      = 1'b1;

    tok_res.token_class  = ltc_pkg::is_op(c) ? ltc_pkg::CLS_OPERATOR : ltc_pkg::CLS_DELIMITER;
    tok_res.token_text   = {56'h0, c};
    tok_res.token_length = 4'd1;
    tok_res.truncated    = 1'b0;
    tok_res.run_end      = 1'b1;

    push.n      = 2'd0;
    push.first  = word_res;
    push.second = tok_res;
    if (item_fire) begin
      priority if (is_od && pending) begin
        push.n                = 2'd2;
        push.first.run_end    = 1'b0;
      end else if (is_od) begin
        push.n     = 2'd1;
        push.first = tok_res;
      end else if (flush) begin
        push.n = 2'd1;
      end else begin
        push.n = 2'd0;
      end
    end

    if (flush) begin
      word_length_next   = 4'd0;
      word_overflow_next = 1'b0;
    end else begin
      word_length_next   = len_eff;
      word_overflow_next = ovf_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length   <= 4'd0;
      word_overflow <= 1'b0;
    end else if (item_fire) begin
      word_length   <= word_length_next;
      word_overflow <= word_overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAXC; i++) begin
      if (item_fire && append && word_length == 4'(i)) word_buffer[i] <= c;
    end
  end

  ltc_out_fifo u_out_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room2       (room2),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_item  (token_item)
  );

  `LTC_ASSERT_ALWAYS(a_len_bound, word_length <= 4'(MAXC))
  `LTC_ASSERT_IMPLY(a_ovf_full, word_overflow, word_length == 4'(MAXC))
  `LTC_ASSERT_IMPLY(a_two_only_od, push.n == 2'd2, is_od && pending)
  `LTC_ASSERT_NEXT(a_accept_held, char_valid && char_ready, item_valid)
  `LTC_ASSERT_NEXT(a_flush_clears, item_fire && flush, word_length == 4'd0 && !word_overflow)

endmodule
